// ===== design/sun_direction_from_clock_macros.svh =====
// Assertion macros shared by the sun direction block.
`ifndef SUN_DIRECTION_FROM_CLOCK_MACROS_SVH
`define SUN_DIRECTION_FROM_CLOCK_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SDC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sdc_pkg.sv =====
// Shared types, constants and the arctangent table for the sun direction block.
`timescale 1ns / 1ps

package sdc_pkg;

  // Rotation depth and table size
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  // Datapath widths
  localparam int XY_W       = 32;
  localparam int ANG_W      = 25;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [XY_W-1:0]  xy_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LATITUDE   = 1'b0,
    REG_BRIGHTNESS = 1'b1
  } cfg_reg_t;

  // Fixed-point constants (degrees Q16, latitude Q8, hours Q16, vectors Q30)
  localparam xy_t                CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic signed [15:0] LAT_LIMIT_Q8    = 16'sd23040;
  localparam logic signed [15:0] BRIGHT_RESET    = 16'sd256;
  localparam logic signed [21:0] NOON_Q16        = 22'sd786432;
  localparam logic signed [25:0] DEG90_Q16       = 26'sd5898240;
  localparam logic signed [25:0] DEG180_Q16      = 26'sd11796480;

  // State of both rotations as it travels down the row of cells
  typedef struct packed {
    xy_t  hx;
    xy_t  hy;
    ang_t hz;
    xy_t  lx;
    xy_t  ly;
    ang_t lz;
    logic flip;
  } cordic_pair_t;

  // Arctangent of 2^-i in degrees Q16, rounded to nearest
  function automatic ang_t atan_q16(input logic [4:0] idx);
    ang_t a;
    unique case (idx)
      5'd0:    a = 25'sd2949120;
      5'd1:    a = 25'sd1740967;
      5'd2:    a = 25'sd919879;
      5'd3:    a = 25'sd466945;
      5'd4:    a = 25'sd234379;
      5'd5:    a = 25'sd117304;
      5'd6:    a = 25'sd58666;
      5'd7:    a = 25'sd29335;
      5'd8:    a = 25'sd14668;
      5'd9:    a = 25'sd7334;
      5'd10:   a = 25'sd3667;
      5'd11:   a = 25'sd1833;
      5'd12:   a = 25'sd917;
      5'd13:   a = 25'sd458;
      5'd14:   a = 25'sd229;
      5'd15:   a = 25'sd115;
      5'd16:   a = 25'sd57;
      5'd17:   a = 25'sd29;
      5'd18:   a = 25'sd14;
      5'd19:   a = 25'sd7;
      5'd20:   a = 25'sd4;
      5'd21:   a = 25'sd2;
      5'd22:   a = 25'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== design/sdc_if.sv =====
// Valid/ready channel interfaces for time beats in and direction beats out.
`timescale 1ns / 1ps

interface sdc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] clock_hours;

  modport source (output valid, output clock_hours, input ready);
  modport sink   (input valid, input clock_hours, output ready);
endinterface

interface sdc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic        [14:0] direct_level;

  modport source (output valid, output dir_x, output dir_y, output dir_z,
                  output direct_level, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                  input direct_level, output ready);
endinterface

// ===== design/sdc_prep.sv =====
// Front stages: wrap the clock time, form the hour angle and load the rotations.
`timescale 1ns / 1ps

module sdc_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [31:0]   clock_hours,
  input  logic signed [15:0]   latitude,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output sdc_pkg::cordic_pair_t dn_data
);

  // Stage A: hour modulo 24, fraction and clamped latitude
  logic               a_valid_r;
  logic               a_ready;
  logic [4:0]         hr_r, hr_nxt;
  logic [15:0]        frac_r;
  logic signed [15:0] lat_r, lat_nxt;

  // Stage B: loaded rotation state
  logic                  b_valid_r;
  sdc_pkg::cordic_pair_t b_data_r, b_data_nxt;

  // Intermediate values of the wrap
  logic [16:0] biased;
  logic [13:0] quo;
  logic [4:0]  dsum;
  logic [1:0]  rem3;

  // Reduce the integer hour modulo 24: bias to unsigned, split into mod 8 and mod 3
  always_comb begin
    logic [4:0] s;
    biased = {1'b0, ~clock_hours[31], clock_hours[30:16]} + 17'd16;
    quo    = biased[16:3];
    dsum   = '0;
    for (int k = 0; k < 7; k++) begin
      dsum = dsum + {3'b000, quo[2*k +: 2]};
    end
    s = dsum;
    if (s >= 5'd12) s = s - 5'd12;
    if (s >= 5'd6)  s = s - 5'd6;
    if (s >= 5'd3)  s = s - 5'd3;
    rem3   = s[1:0];
    hr_nxt = {rem3, biased[2:0]};
  end

  // Clamp latitude to plus or minus 90 degrees
  always_comb begin
    if (latitude > sdc_pkg::LAT_LIMIT_Q8) begin
      lat_nxt = sdc_pkg::LAT_LIMIT_Q8;
    end else if (latitude < -sdc_pkg::LAT_LIMIT_Q8) begin
      lat_nxt = -sdc_pkg::LAT_LIMIT_Q8;
    end else begin
      lat_nxt = latitude;
    end
  end

  // Hour angle, folded into the rotation range
  always_comb begin
    logic [20:0]        w;
    logic signed [21:0] d;
    logic signed [25:0] ha;
    logic signed [25:0] ha_f;
    w  = {hr_r, frac_r};
    d  = $signed({1'b0, w}) - sdc_pkg::NOON_Q16;
    ha = ({{4{d[21]}}, d} <<< 4) - {{4{d[21]}}, d};
    b_data_nxt.flip = 1'b0;
    ha_f = ha;
    if (ha > sdc_pkg::DEG90_Q16) begin
      ha_f = ha - sdc_pkg::DEG180_Q16;
      b_data_nxt.flip = 1'b1;
    end else if (ha < -sdc_pkg::DEG90_Q16) begin
      ha_f = ha + sdc_pkg::DEG180_Q16;
      b_data_nxt.flip = 1'b1;
    end
    b_data_nxt.hx = sdc_pkg::CORDIC_GAIN_Q30;
    b_data_nxt.hy = '0;
    b_data_nxt.hz = ha_f[sdc_pkg::ANG_W-1:0];
    b_data_nxt.lx = sdc_pkg::CORDIC_GAIN_Q30;
    b_data_nxt.ly = '0;
    b_data_nxt.lz = $signed({lat_r[15], lat_r, 8'h00});
  end

  assign a_ready  = !b_valid_r || dn_ready;
  assign up_ready = !a_valid_r || a_ready;

  // Stage A registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (up_ready) begin
      a_valid_r <= up_valid;
    end
    if (up_valid && up_ready) begin
      hr_r   <= hr_nxt;
      frac_r <= clock_hours[15:0];
      lat_r  <= lat_nxt;
    end
  end

  // Stage B registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_ready) begin
      b_valid_r <= a_valid_r;
    end
    if (a_valid_r && a_ready) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_data  = b_data_r;

endmodule

// ===== design/sdc_cell.sv =====
// One CORDIC cell: a single rotation step for the hour angle and the latitude.
`timescale 1ns / 1ps

module sdc_cell #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  sdc_pkg::cordic_pair_t up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output sdc_pkg::cordic_pair_t dn_data
);

  localparam sdc_pkg::ang_t ATAN = sdc_pkg::atan_q16(5'(STEP));

  logic                  valid_r;
  sdc_pkg::cordic_pair_t data_r, data_nxt;

  sdc_pkg::xy_t  hx, hy, lx, ly;
  sdc_pkg::ang_t hz, lz;

  assign hx = up_data.hx;
  assign hy = up_data.hy;
  assign hz = up_data.hz;
  assign lx = up_data.lx;
  assign ly = up_data.ly;
  assign lz = up_data.lz;

  // Rotate both vectors towards zero residual angle
  always_comb begin
    data_nxt.flip = up_data.flip;
    if (!hz[sdc_pkg::ANG_W-1]) begin
      data_nxt.hx = hx - (hy >>> STEP);
      data_nxt.hy = hy + (hx >>> STEP);
      data_nxt.hz = hz - ATAN;
    end else begin
      data_nxt.hx = hx + (hy >>> STEP);
      data_nxt.hy = hy - (hx >>> STEP);
      data_nxt.hz = hz + ATAN;
    end
    if (!lz[sdc_pkg::ANG_W-1]) begin
      data_nxt.lx = lx - (ly >>> STEP);
      data_nxt.ly = ly + (lx >>> STEP);
      data_nxt.lz = lz - ATAN;
    end else begin
      data_nxt.lx = lx + (ly >>> STEP);
      data_nxt.ly = ly - (lx >>> STEP);
      data_nxt.lz = lz + ATAN;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  // Hold the beat until the next cell takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== design/sdc_post.sv =====
// Back stages: undo the fold, form the direction products, round and scale light.
`timescale 1ns / 1ps

module sdc_post (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  sdc_pkg::cordic_pair_t up_data,
  input  logic signed [15:0]    brightness,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic signed [15:0]    dir_x,
  output logic signed [15:0]    dir_y,
  output logic signed [15:0]    dir_z,
  output logic [14:0]           direct_level
);

  // Saturate a rounded, negated component to the symmetric Q1.15 range
  function automatic logic signed [15:0] sat_q15(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767) begin
      r = 16'sd32767;
    end else if (v < -21'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Stage 1: sines and cosines with the fold undone
  logic         s1_valid_r, s1_ready;
  sdc_pkg::xy_t ch_r, sh_r, cl_r, sl_r;
  sdc_pkg::xy_t hx, hy;

  // Stage 2: products and x component
  logic               s2_valid_r, s2_ready;
  logic signed [63:0] pc_r, ps_r, pc_nxt, ps_nxt;
  logic signed [15:0] dx2_r, dx2_nxt;

  // Stage 3: y and z components
  logic               s3_valid_r, s3_ready;
  logic signed [15:0] dx3_r, dy3_r, dz3_r, dy3_nxt, dz3_nxt;

  // Stage 4: output register
  logic               s4_valid_r;
  logic signed [15:0] dx4_r, dy4_r, dz4_r;
  logic [14:0]        lvl4_r, lvl4_nxt;

  assign hx = up_data.hx;
  assign hy = up_data.hy;

  assign s3_ready = !s4_valid_r || dn_ready;
  assign s2_ready = !s3_valid_r || s3_ready;
  assign s1_ready = !s2_valid_r || s2_ready;
  assign up_ready = !s1_valid_r || s1_ready;

  // Stage 1: negate the hour vector where it was moved by half a turn
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (up_ready) begin
      s1_valid_r <= up_valid;
    end
    if (up_valid && up_ready) begin
      ch_r <= up_data.flip ? -hx : hx;
      sh_r <= up_data.flip ? -hy : hy;
      cl_r <= up_data.lx;
      sl_r <= up_data.ly;
    end
  end

  // Multiply by the latitude terms; round the x component
  always_comb begin
    logic signed [32:0] sr;
    logic signed [17:0] rx;
    pc_nxt  = cl_r * ch_r;
    ps_nxt  = sl_r * ch_r;
    sr      = {sh_r[31], sh_r} + 33'sh4000;
    rx      = sr[32:15];
    dx2_nxt = sat_q15(-{{3{rx[17]}}, rx});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s1_valid_r && s1_ready) begin
      pc_r  <= pc_nxt;
      ps_r  <= ps_nxt;
      dx2_r <= dx2_nxt;
    end
  end

  // Round the products down to Q1.15 and negate
  always_comb begin
    logic signed [64:0] sy, sz;
    logic signed [19:0] ry, rz;
    sy      = {pc_r[63], pc_r} + 65'sh1000_0000_0000;
    sz      = {ps_r[63], ps_r} + 65'sh1000_0000_0000;
    ry      = sy[64:45];
    rz      = sz[64:45];
    dy3_nxt = sat_q15(-{ry[19], ry});
    dz3_nxt = sat_q15(-{rz[19], rz});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s3_valid_r <= s2_valid_r;
    end
    if (s2_valid_r && s2_ready) begin
      dx3_r <= dx2_r;
      dy3_r <= dy3_nxt;
      dz3_r <= dz3_nxt;
    end
  end

  // Scale brightness by the daylight fraction
  always_comb begin
    logic [14:0]        day;
    logic [14:0]        br;
    logic signed [15:0] ndy;
    logic [29:0]        lsum;
    ndy      = 16'sd0 - dy3_r;
    day      = dy3_r[15] ? ndy[14:0] : 15'd0;
    br       = brightness[15] ? 15'd0 : brightness[14:0];
    lsum     = 30'(br) * 30'(day) + 30'd16384;
    lvl4_nxt = lsum[29:15];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s4_valid_r <= s3_valid_r;
    end
    if (s3_valid_r && s3_ready) begin
      dx4_r  <= dx3_r;
      dy4_r  <= dy3_r;
      dz4_r  <= dz3_r;
      lvl4_r <= lvl4_nxt;
    end
  end

  assign dn_valid     = s4_valid_r;
  assign dir_x        = dx4_r;
  assign dir_y        = dy4_r;
  assign dir_z        = dz4_r;
  assign direct_level = lvl4_r;

endmodule

// ===== design/sun_direction_from_clock.sv =====
// Beats pass through the prep stages, the row of rotation cells, then the post stages.
// Throughput: one beat per cycle while results are taken; every stage and cell has its
// own register and valid, so the pipeline keeps taking beats while a result waits,
// until it fills. The row of rotation cells, one per CORDIC step up to ATAN_ENTRIES,
// sets the depth. Reset (synchronous, active low) empties every stage and loads
// latitude 0 and brightness 256.
`timescale 1ns / 1ps
`include "sun_direction_from_clock_macros.svh"

module sun_direction_from_clock #(
  parameter int CORDIC_STEPS = sdc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sdc_in_if.sink                         in_bus,
  sdc_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [sdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NCELL = (CORDIC_STEPS < sdc_pkg::ATAN_ENTRIES) ? CORDIC_STEPS
                                                                : sdc_pkg::ATAN_ENTRIES;

  logic signed [15:0] latitude_r;
  logic signed [15:0] brightness_r;

  logic [NCELL:0]        c_valid;
  logic [NCELL:0]        c_ready;
  sdc_pkg::cordic_pair_t c_data [NCELL+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latitude_r   <= '0;
      brightness_r <= sdc_pkg::BRIGHT_RESET;
    end else if (cfg_we) begin
      unique case (sdc_pkg::cfg_reg_t'(cfg_index))
        sdc_pkg::REG_LATITUDE:   latitude_r   <= $signed(cfg_wdata);
        sdc_pkg::REG_BRIGHTNESS: brightness_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Wrap time and load the rotations
  sdc_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_bus.valid),
    .up_ready    (in_bus.ready),
    .clock_hours (in_bus.clock_hours),
    .latitude    (latitude_r),
    .dn_valid    (c_valid[0]),
    .dn_ready    (c_ready[0]),
    .dn_data     (c_data[0])
  );

  // Row of rotation cells
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    sdc_cell #(
      .STEP (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[k]),
      .up_ready (c_ready[k]),
      .up_data  (c_data[k]),
      .dn_valid (c_valid[k+1]),
      .dn_ready (c_ready[k+1]),
      .dn_data  (c_data[k+1])
    );
  end

  // Products, rounding and light level
  sdc_post u_post (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (c_valid[NCELL]),
    .up_ready     (c_ready[NCELL]),
    .up_data      (c_data[NCELL]),
    .brightness   (brightness_r),
    .dn_valid     (out_bus.valid),
    .dn_ready     (out_bus.ready),
    .dir_x        (out_bus.dir_x),
    .dir_y        (out_bus.dir_y),
    .dir_z        (out_bus.dir_z),
    .direct_level (out_bus.direct_level)
  );

  // No direct light with the sun on or below the horizon
  `SDC_ASSERT_IMPLY(a_dark_no_light, clk, rst_n, out_bus.valid && !out_bus.dir_y[15], out_bus.direct_level == 15'd0, "direct light with the sun down")
  // No direct light from a negative brightness
  `SDC_ASSERT_IMPLY(a_neg_bright, clk, rst_n, out_bus.valid && brightness_r[15], out_bus.direct_level == 15'd0, "direct light from negative brightness")
  // Rounded level never reaches full scale
  `SDC_ASSERT_IMPLY(a_level_max, clk, rst_n, out_bus.valid, out_bus.direct_level != 15'h7FFF, "direct level at full scale")
  // A latitude write lands in its register
  `SDC_ASSERT_NEXT(a_lat_write, clk, rst_n, cfg_we && (cfg_index == sdc_pkg::REG_LATITUDE), latitude_r == $signed($past(cfg_wdata)), "latitude write lost")

endmodule

// ===== verif/tb_sun_direction_from_clock.sv =====
// Testbench for the sun direction block: clock times in, sun vectors and light levels checked.
`timescale 1ns / 1ps

module tb_sun_direction_from_clock;

  localparam int     PIPE_DEPTH  = sdc_pkg::CORDIC_STEPS_DEF + 6;
  localparam int     STALL_LIMIT = 4000;
  localparam longint DEG_Q16     = 65536;
  localparam longint DAY_HRS_Q16 = 24 * 65536;
  localparam longint NOON_HRS    = 12 * 65536;
  localparam longint GAIN_Q30    = 652032874;
  localparam longint LAT_MAX_Q8  = 23040;
  localparam longint HALF_Q15    = 64'sd1 <<< 14;
  localparam longint HALF_Q45    = 64'sd1 <<< 44;
  localparam logic signed [31:0] HOUR_Q16 = 32'sd65536;
  localparam logic signed [31:0] DAY_Q16  = 32'sd1572864;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [14:0]        lvl;
  } sun_dir_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  sdc_pkg::cfg_reg_t cfg_index;
  logic [15:0] cfg_wdata;

  sdc_in_if  in_bus ();
  sdc_out_if out_bus ();

  sun_direction_from_clock dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Arctangent of 2^-i in degrees Q16
  longint atan_deg [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Shadow copies of the two registers
  logic signed [15:0] lat_reg;
  logic signed [15:0] bright_reg;

  sun_dir_t sun_expected [$];
  int gap_pct;
  int stall_pct;
  int hold_left;
  int idle_cycles;
  int mismatch_count;
  int beats_in;
  int beats_out;
  int settings_used;

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Rotate the gain vector through an angle in degrees Q16, giving cos and sin in Q30
  function automatic void sun_rotate(input longint ang, output longint cos_q30,
                                     output longint sin_q30);
    longint x, y, z, xs, ys;
    bit     flip;
    x    = GAIN_Q30;
    y    = 0;
    z    = ang;
    flip = 1'b0;
    // fold into -90..90 and negate afterwards
    if (z > 90 * DEG_Q16) begin
      z -= 180 * DEG_Q16;
      flip = 1'b1;
    end else if (z < -90 * DEG_Q16) begin
      z += 180 * DEG_Q16;
      flip = 1'b1;
    end
    for (int i = 0; i < sdc_pkg::CORDIC_STEPS_DEF && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= atan_deg[i];
      end else begin
        x += ys;
        y -= xs;
        z += atan_deg[i];
      end
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  function automatic longint clip_q15(input longint v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  // Sun vector and direct level for one clock time under the current registers
  function automatic sun_dir_t predict_sun(input logic signed [31:0] hrs);
    sun_dir_t b;
    longint   t, w, ha, lat, ch, sh, cl, sl, dx, dy, dz, day, br, lvl;
    t = longint'(hrs);
    w = t % DAY_HRS_Q16;
    if (w < 0) w += DAY_HRS_Q16;
    ha = (w - NOON_HRS) * 15;
    lat = longint'(lat_reg);
    if (lat > LAT_MAX_Q8) lat = LAT_MAX_Q8;
    if (lat < -LAT_MAX_Q8) lat = -LAT_MAX_Q8;
    lat = lat * 256;
    sun_rotate(ha, ch, sh);
    sun_rotate(lat, cl, sl);
    dx = clip_q15(-((sh + HALF_Q15) >>> 15));
    dy = clip_q15(-((cl * ch + HALF_Q45) >>> 45));
    dz = clip_q15(-((sl * ch + HALF_Q45) >>> 45));
    day = (-dy < 0) ? 0 : -dy;
    br  = (bright_reg < 0) ? 0 : longint'(bright_reg);
    lvl = (br * day + HALF_Q15) >>> 15;
    if (lvl > 32767) lvl = 32767;
    b.x   = 16'(dx);
    b.y   = 16'(dy);
    b.z   = 16'(dz);
    b.lvl = 15'(lvl);
    return b;
  endfunction

  // Predict on each input beat, check each result beat, count quiet cycles
  always @(posedge clk) begin : track
    sun_dir_t want;
    bit       moved;
    moved = 1'b0;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      sun_expected.push_back(predict_sun(in_bus.clock_hours));
      beats_in++;
      moved = 1'b1;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      moved = 1'b1;
      beats_out++;
      if (sun_expected.size() == 0) begin
        $error("result beat with no time beat pending");
        mismatch_count++;
      end else begin
        want = sun_expected.pop_front();
        if (out_bus.dir_x !== want.x) begin
          $error("dir_x: expected %0d, got %0d", want.x, out_bus.dir_x);
          mismatch_count++;
        end
        if (out_bus.dir_y !== want.y) begin
          $error("dir_y: expected %0d, got %0d", want.y, out_bus.dir_y);
          mismatch_count++;
        end
        if (out_bus.dir_z !== want.z) begin
          $error("dir_z: expected %0d, got %0d", want.z, out_bus.dir_z);
          mismatch_count++;
        end
        if (out_bus.direct_level !== want.lvl) begin
          $error("direct_level: expected %0d, got %0d", want.lvl, out_bus.direct_level);
          mismatch_count++;
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  // Result side: random stalls, or a counted hold-off when one is requested
  initial begin : result_sink
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Give up when nothing moves for too long
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
    $display("sun_direction_from_clock: mismatch");
    $finish;
  end

  // Offer one time beat and hold it until taken; called and returns at a falling edge
  task automatic send_time(input logic signed [31:0] hrs);
    while ($urandom_range(99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.clock_hours <= hrs;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    @(negedge clk);
  endtask

  // Drop valid, drain every pending result and let the pipe empty
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sun_expected.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH) @(negedge clk);
  endtask

  task automatic cfg_write(input sdc_pkg::cfg_reg_t idx, input logic signed [15:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == sdc_pkg::REG_LATITUDE) lat_reg = val;
    else bright_reg = val;
    settings_used++;
  endtask

  // Random clock time: full range, one day, negative days, or near a quarter day
  function automatic logic signed [31:0] pick_time();
    logic signed [31:0] base;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, DAY_Q16 - 1);
      2: return -$signed($urandom_range(1, 5 * DAY_Q16));
      default: begin
        base = $signed($urandom_range(0, 3)) * 6 * HOUR_Q16;
        base += ($signed($urandom_range(0, 6)) - 3) * DAY_Q16;
        return base + $signed($urandom_range(0, 2048)) - 1024;
      end
    endcase
  endfunction

  // Wrap of the day, both signs, and hour angles on and just past plus or minus 90
  task automatic test_hour_wrap();
    gap_pct   = 0;
    stall_pct = 0;
    send_time(0);
    send_time(6 * HOUR_Q16);
    send_time(6 * HOUR_Q16 - 1);
    send_time(12 * HOUR_Q16);
    send_time(18 * HOUR_Q16);
    send_time(18 * HOUR_Q16 + 1);
    send_time(24 * HOUR_Q16);
    send_time(-1);
    send_time(-6 * HOUR_Q16);
    send_time(32'sh7FFF_FFFF);
    send_time(32'sh8000_0000);
    send_time(9 * HOUR_Q16 + 32768);
  endtask

  // Latitude at and beyond both poles
  task automatic test_latitude_clamp();
    cfg_write(sdc_pkg::REG_LATITUDE, 16'sd23040);
    send_time(12 * HOUR_Q16);
    send_time(9 * HOUR_Q16);
    cfg_write(sdc_pkg::REG_LATITUDE, -16'sd23040);
    send_time(12 * HOUR_Q16);
    send_time(15 * HOUR_Q16);
    cfg_write(sdc_pkg::REG_LATITUDE, 16'sd32767);
    send_time(12 * HOUR_Q16);
    send_time(3 * HOUR_Q16);
    cfg_write(sdc_pkg::REG_LATITUDE, -16'sd32768);
    send_time(12 * HOUR_Q16);
    send_time(21 * HOUR_Q16);
  endtask

  // Negative, zero and full brightness with the sun overhead
  task automatic test_brightness_floor();
    cfg_write(sdc_pkg::REG_LATITUDE, 16'sd0);
    cfg_write(sdc_pkg::REG_BRIGHTNESS, -16'sd32768);
    send_time(12 * HOUR_Q16);
    cfg_write(sdc_pkg::REG_BRIGHTNESS, 16'sd0);
    send_time(12 * HOUR_Q16);
    cfg_write(sdc_pkg::REG_BRIGHTNESS, 16'sd32767);
    send_time(12 * HOUR_Q16);
  endtask

  // Random times under random registers, across the idle mixes
  task automatic test_random_days();
    logic signed [15:0] lat, br;
    for (int p = 0; p < 8; p++) begin
      lat = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                         : 16'($signed($urandom_range(0, 46080)) - 23040);
      br  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32767));
      cfg_write(sdc_pkg::REG_LATITUDE, lat);
      cfg_write(sdc_pkg::REG_BRIGHTNESS, br);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 8; stall_pct = 8; end
      endcase
      repeat (200) send_time(pick_time());
    end
  endtask

  // Hold results back long enough for the pipe to fill and stall its input
  task automatic test_result_hold_off();
    settle();
    gap_pct   = 0;
    stall_pct = 0;
    hold_left = 300;
    repeat (60) send_time(pick_time());
  endtask

  initial begin : main
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = sdc_pkg::REG_LATITUDE;
    cfg_wdata          = '0;
    in_bus.valid       = 1'b0;
    in_bus.clock_hours = '0;
    lat_reg            = 16'sd0;
    bright_reg         = sdc_pkg::BRIGHT_RESET;
    gap_pct            = 0;
    stall_pct          = 0;
    hold_left          = 0;
    mismatch_count     = 0;
    beats_in           = 0;
    beats_out          = 0;
    settings_used      = 0;

    // Reset once
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_hour_wrap();
    test_latitude_clamp();
    test_brightness_floor();
    test_random_days();
    test_result_hold_off();
    settle();

    $display("Ran %0d clock times through %0d register writes, polar and negative settings",
             beats_in, settings_used);
    $display("included, under four idle mixes and one long result hold-off; %0d results checked.",
             beats_out);
    if (mismatch_count == 0 && sun_expected.size() == 0) begin
      $display("sun_direction_from_clock: match");
    end else begin
      $display("sun_direction_from_clock: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sdc_pkg.sv
design/sdc_if.sv
design/sdc_prep.sv
design/sdc_cell.sv
design/sdc_post.sv
design/sun_direction_from_clock.sv
verif/tb_sun_direction_from_clock.sv
